// ----- rtl/ptsch_pkg.sv -----
// Shared types and constants for the periodic timer scheduler.
package ptsch_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_FIRED   = 3'd2,
    ST_TICKED  = 3'd3,
    ST_REMOVED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_REMOVE,
    S_TICK,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic        used;
    logic        cancelled;
    logic        pend;
    logic [31:0] ident;
    logic [31:0] period;
    logic [31:0] deadline;
  } slot_t;
endpackage

// ----- rtl/ptsch_cell.sv -----
// One timer slot cell of the rotating slot chain.
module ptsch_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  ptsch_pkg::slot_t d,
  output ptsch_pkg::slot_t q
);
  import ptsch_pkg::*;

  logic        used_r, cancelled_r, pend_r;
  logic [31:0] ident_r, period_r, deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      cancelled_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (shift) begin
      used_r      <= d.used;
      cancelled_r <= d.cancelled;
      pend_r      <= d.pend;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ident_r    <= d.ident;
      period_r   <= d.period;
      deadline_r <= d.deadline;
    end
  end

  assign q = '{used: used_r, cancelled: cancelled_r, pend: pend_r,
               ident: ident_r, period: period_r, deadline: deadline_r};
endmodule

// ----- rtl/periodic_timer_scheduler.sv -----
// Top level of the periodic timer scheduler: command sequencer and slot ring.
// The sixteen timer slots sit in a ring of cells that rotates by one slot per
// cycle while a command runs; the sequencer works on the slot at the head.
// After the accept cycle, add and remove take one revolution and then present the
// result. A tick revolves for as long as due timers remain, since each
// revolution picks the next timer in deadline order and fires it on the next
// one; a stalled output holds the ring. An unused command is dropped in its
// accept cycle. Items are taken one at a time, and a new item waits until the
// previous final result has been taken or is taken in the same cycle.
module periodic_timer_scheduler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // cmd[1:0], now_ms[33:2], period_ms[65:34], timer_ident[97:66]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // status[2:0], result_ident[34:3], fired_period[66:35], next_delay[98:67]
  output logic         out_tlast
);
  import ptsch_pkg::*;

  slot_t cell_q [NUM_SLOTS];
  slot_t cell_d [NUM_SLOTS];
  logic  shift;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0] now_r, per_r, id_r, next_ident_r, next_ident_nxt;
  logic        hit_r, hit_nxt, first_r, first_nxt;
  logic        fire_vld_r, fire_vld_nxt;
  logic [IDX_W-1:0] fire_idx_r, fire_idx_nxt, pick_idx_r, pick_idx_nxt;
  logic        pick_vld_r, pick_vld_nxt;
  logic [31:0] age_r, age_nxt, best_r, best_nxt;
  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_ident_r, out_ident_nxt, out_period_r, out_period_nxt;
  logic [31:0] out_delay_r, out_delay_nxt;

  slot_t head, nh;
  logic  emit, out_free, pass_end, nh_due, h_due;
  logic [31:0] age, dly;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ring
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign cell_d[i] = nh;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    ptsch_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(cell_d[i]), .q(cell_q[i]));
  end

  assign head     = cell_q[0];
  assign out_free = !out_valid_r || out_tready;
  assign pass_end = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign h_due    = ((now_r - head.deadline) < 32'h8000_0000);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    next_ident_nxt = next_ident_r;
    hit_nxt        = hit_r;
    first_nxt      = first_r;
    fire_vld_nxt   = fire_vld_r;
    fire_idx_nxt   = fire_idx_r;
    pick_vld_nxt   = pick_vld_r;
    pick_idx_nxt   = pick_idx_r;
    age_nxt        = age_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_ident_nxt  = out_ident_r;
    out_period_nxt = out_period_r;
    out_delay_nxt  = out_delay_r;
    out_last_nxt   = out_last_r;
    nh             = head;
    emit           = 1'b0;
    shift          = 1'b0;
    age            = '0;
    dly            = '0;
    nh_due         = 1'b0;
    // hold the next item while a result still waits
    in_tready      = (state_r == S_IDLE) && out_free;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && out_free) begin
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          first_nxt = 1'b1;
          fire_vld_nxt = 1'b0;
          pick_vld_nxt = 1'b0;
          best_nxt = NO_DEADLINE;
          unique case (cmd_t'(in_tdata[1:0]))
            CMD_TICK:   state_nxt = S_TICK;
            CMD_ADD:    state_nxt = S_ADD;
            CMD_REMOVE: state_nxt = S_REMOVE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        shift = 1'b1;
        if (!hit_r && !head.used) begin
          nh.used      = 1'b1;
          nh.cancelled = 1'b0;
          nh.pend      = 1'b0;
          nh.ident     = next_ident_r;
          nh.period    = per_r;
          nh.deadline  = now_r + per_r;
          hit_nxt      = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (pass_end) begin
          state_nxt = S_FINAL;
          out_status_nxt = hit_nxt ? ST_ADDED : ST_FULL;
          out_ident_nxt  = hit_nxt ? next_ident_r : 32'd0;
          out_period_nxt = '0;
          out_delay_nxt  = '0;
          if (hit_nxt) next_ident_nxt = next_ident_r + 32'd1;
        end
      end
      S_REMOVE: begin
        shift = 1'b1;
        if (!hit_r && head.used && !head.cancelled && head.ident == id_r) begin
          nh.cancelled = 1'b1;
          hit_nxt      = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (pass_end) begin
          state_nxt = S_FINAL;
          out_status_nxt = ST_REMOVED;
          out_ident_nxt  = '0;
          out_period_nxt = '0;
          out_delay_nxt  = '0;
        end
      end
      S_TICK: begin
        // mark due slots on the first revolution, free the due ones that are cancelled
        if (first_r) begin
          nh.pend = 1'b0;
          if (head.used && h_due) begin
            if (head.cancelled) begin
              nh.used      = 1'b0;
              nh.cancelled = 1'b0;
            end else begin
              nh.pend = 1'b1;
            end
          end
        end
        if (fire_vld_r && idx_r == fire_idx_r) begin
          emit        = 1'b1;
          nh.pend     = 1'b0;
          nh.deadline = now_r + head.period;
        end
        shift = !(emit && !out_free);
        if (shift) begin
          if (emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FIRED;
            out_ident_nxt  = head.ident;
            out_period_nxt = head.period;
            out_delay_nxt  = '0;
            out_last_nxt   = 1'b0;
          end
          age = now_r - nh.deadline;
          if (nh.pend && (!pick_vld_r || age > age_r)) begin
            pick_vld_nxt = 1'b1;
            pick_idx_nxt = idx_r;
            age_nxt      = age;
          end
          nh_due = (age < 32'h8000_0000);
          dly    = nh_due ? 32'd0 : (nh.deadline - now_r);
          if (nh.used && dly < best_r) best_nxt = dly;
          idx_nxt = idx_r + 1'b1;
          if (pass_end) begin
            first_nxt = 1'b0;
            if (pick_vld_nxt) begin
              fire_vld_nxt = 1'b1;
              fire_idx_nxt = pick_idx_nxt;
              pick_vld_nxt = 1'b0;
              best_nxt     = NO_DEADLINE;
            end else begin
              fire_vld_nxt = 1'b0;
              state_nxt    = S_FINAL;
            end
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (!first_r) begin
            out_status_nxt = ST_TICKED;
            out_ident_nxt  = '0;
            out_period_nxt = '0;
            out_delay_nxt  = best_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      next_ident_r <= 32'd1;
      hit_r        <= 1'b0;
      first_r      <= 1'b0;
      fire_vld_r   <= 1'b0;
      pick_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      next_ident_r <= next_ident_nxt;
      hit_r        <= hit_nxt;
      first_r      <= first_nxt;
      fire_vld_r   <= fire_vld_nxt;
      pick_vld_r   <= pick_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fire_idx_r   <= fire_idx_nxt;
    pick_idx_r   <= pick_idx_nxt;
    age_r        <= age_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_ident_r  <= out_ident_nxt;
    out_period_r <= out_period_nxt;
    out_delay_r  <= out_delay_nxt;
    out_last_r   <= out_last_nxt;
    if (in_tvalid && in_tready) begin
      now_r <= in_tdata[33:2];
      per_r <= (in_tdata[65:34] == 32'd0) ? 32'd1 : in_tdata[65:34];
      id_r  <= in_tdata[97:66];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_delay_r, out_period_r, out_ident_r, out_status_r};

`ifndef NO_ASSERTIONS
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (idx_r == '0))
    else $error("ring not aligned while idle");
  a_fire_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire_vld_r |-> (state_r == S_TICK))
    else $error("pending fire outside tick");
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINAL && out_free) |=> (out_tvalid && out_tlast))
    else $error("final item not presented");
`endif
endmodule
